// ----- src/rem_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, limits and handshake types for the rating error metrics block.
// No dependencies; used by rem_divsqrt and rating_error_metrics.
package rem_pkg;

  localparam int RATING_W  = 16;
  localparam int ABS_W     = 16;
  localparam int SQ_W      = 2 * ABS_W;
  localparam int SQ_SUM_W  = 54;
  localparam int ABS_SUM_W = 38;
  localparam int CNT_W     = 21;
  localparam int OUT_W     = 17;
  localparam int MAX_PAIRS = 1048576;

  localparam int ROOT_W    = SQ_SUM_W / 2;
  localparam int REM_W     = ROOT_W + 3;
  localparam int STEP_W    = $clog2(SQ_SUM_W);

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } rem_op_e;

  typedef struct packed {
    logic    start;
    rem_op_e op;
  } rem_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_sts_t;

endpackage

// ----- src/rem_divsqrt.sv -----
`timescale 1ns / 1ps
// Bit-serial restoring divider and digit-by-digit square root on one shared subtractor.
// Depends on rem_pkg for widths, the operation code and the command and status structs.
module rem_divsqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rem_pkg::rem_cmd_t             cmd_i,
  input  logic [rem_pkg::SQ_SUM_W-1:0]  operand_i,
  input  logic [rem_pkg::CNT_W-1:0]     divisor_i,
  output rem_pkg::rem_sts_t             sts_o,
  output logic [rem_pkg::SQ_SUM_W-1:0]  result_o
);

  localparam int XW = rem_pkg::SQ_SUM_W;
  localparam int RW = rem_pkg::REM_W;
  localparam int CW = rem_pkg::CNT_W;
  localparam int QW = rem_pkg::ROOT_W;

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  rem_pkg::rem_op_e         op_q, op_d;
  logic [rem_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic [RW-1:0]            rem_q, rem_d;
  logic [XW-1:0]            x_q, x_d;
  logic [XW-1:0]            q_q, q_d;
  logic [CW-1:0]            dvs_q, dvs_d;

  logic [RW-1:0]            op_a;
  logic [RW-1:0]            op_b;
  logic [RW:0]              diff;
  logic                     ge;

  always_comb begin
    if (op_q == rem_pkg::OP_DIV) begin
      op_a = {{(RW-CW-1){1'b0}}, rem_q[CW-1:0], x_q[XW-1]};
      op_b = {{(RW-CW){1'b0}}, dvs_q};
    end else begin
      op_a = {rem_q[RW-3:0], x_q[XW-1:XW-2]};
      op_b = {1'b0, q_q[QW-1:0], 2'b01};
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = ~diff[RW];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    x_d    = x_q;
    q_d    = q_q;
    dvs_d  = dvs_q;
    if (busy_q) begin
      rem_d = ge ? diff[RW-1:0] : op_a;
      q_d   = {q_q[XW-2:0], ge};
      x_d   = (op_q == rem_pkg::OP_DIV) ? {x_q[XW-2:0], 1'b0} : {x_q[XW-3:0], 2'b00};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (cmd_i.start) begin
      busy_d = 1'b1;
      op_d   = cmd_i.op;
      rem_d  = '0;
      q_d    = '0;
      x_d    = operand_i;
      dvs_d  = divisor_i;
      cnt_d  = (cmd_i.op == rem_pkg::OP_DIV) ? rem_pkg::STEP_W'(XW - 1)
                                              : rem_pkg::STEP_W'(QW - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= rem_pkg::OP_DIV;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    x_q   <= x_d;
    q_q   <= q_d;
    dvs_q <= dvs_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign result_o   = q_q;

endmodule

// ----- src/rating_error_metrics.sv -----
`timescale 1ns / 1ps
// Top level: accumulates squared and absolute rating errors and reports RMSE and MAE.
// Depends on rem_pkg and rem_divsqrt.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  actual_rating_i, predicted_rating_i, last_pair_i
//   out      output     out_valid_o/out_ready_i rmse_value_o, mae_value_o, valid_total_o,
//                                               no_valid_flag_o
//
// A pair is accepted with its absolute difference taken, then squared, then accumulated.
// A last pair adds a count check, two 54-step divides and a 27-step root on the shared
// subtract unit in rem_divsqrt. in_ready_o is low while a pair works.
// Reset clears the sums and count at once; no clearing pass.
// The result waits in an output register; new pairs are taken meanwhile, and only the next
// result waits for the register to empty.
module rating_error_metrics (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [rem_pkg::RATING_W-1:0] actual_rating_i,
  input  logic signed [rem_pkg::RATING_W-1:0] predicted_rating_i,
  input  logic                                last_pair_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rem_pkg::OUT_W-1:0]           rmse_value_o,
  output logic [rem_pkg::OUT_W-1:0]           mae_value_o,
  output logic [rem_pkg::CNT_W-1:0]           valid_total_o,
  output logic                                no_valid_flag_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQR  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_WDA  = 3'd4;
  localparam logic [2:0] ST_WDS  = 3'd5;
  localparam logic [2:0] ST_WSR  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  localparam int RW = rem_pkg::RATING_W;
  localparam int AW = rem_pkg::ABS_W;
  localparam int SW = rem_pkg::SQ_SUM_W;
  localparam int BW = rem_pkg::ABS_SUM_W;
  localparam int CW = rem_pkg::CNT_W;
  localparam int OW = rem_pkg::OUT_W;

  logic [2:0]          state_q, state_d;
  logic [AW-1:0]       ad_q, ad_d;
  logic [rem_pkg::SQ_W-1:0] sq_q, sq_d;
  logic                take_q, take_d;
  logic                last_q, last_d;
  logic [SW-1:0]       sq_sum_q, sq_sum_d;
  logic [BW-1:0]       abs_sum_q, abs_sum_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [OW-1:0]       mae_q, mae_d;
  logic [OW-1:0]       rmse_q, rmse_d;
  logic                out_valid_q, out_valid_d;
  logic [OW-1:0]       out_rmse_q, out_rmse_d;
  logic [OW-1:0]       out_mae_q, out_mae_d;
  logic [CW-1:0]       out_cnt_q, out_cnt_d;
  logic                out_flag_q, out_flag_d;

  logic signed [RW:0]  diff;
  logic [RW:0]         diff_abs;
  logic                in_fire;

  rem_pkg::rem_cmd_t   cmd;
  logic [SW-1:0]       unit_x;
  rem_pkg::rem_sts_t   sts;
  logic [SW-1:0]       unit_res;

  rem_divsqrt u_divsqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .operand_i (unit_x),
    .divisor_i (cnt_q),
    .sts_o     (sts),
    .result_o  (unit_res)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;

  always_comb begin
    diff     = {actual_rating_i[RW-1], actual_rating_i}
             - {predicted_rating_i[RW-1], predicted_rating_i};
    diff_abs = diff[RW] ? (-diff) : diff;
  end

  always_comb begin
    state_d     = state_q;
    ad_d        = ad_q;
    sq_d        = sq_q;
    take_d      = take_q;
    last_d      = last_q;
    sq_sum_d    = sq_sum_q;
    abs_sum_d   = abs_sum_q;
    cnt_d       = cnt_q;
    mae_d       = mae_q;
    rmse_d      = rmse_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_rmse_d  = out_rmse_q;
    out_mae_d   = out_mae_q;
    out_cnt_d   = out_cnt_q;
    out_flag_d  = out_flag_q;
    cmd.start   = 1'b0;
    cmd.op      = rem_pkg::OP_DIV;
    unit_x      = {{(SW-BW){1'b0}}, abs_sum_q};

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          ad_d    = diff_abs[AW-1:0];
          take_d  = (predicted_rating_i != '0) && (cnt_q < CW'(rem_pkg::MAX_PAIRS));
          last_d  = last_pair_i;
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        sq_d    = ad_q * ad_q;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (take_q) begin
          sq_sum_d  = sq_sum_q + {{(SW-rem_pkg::SQ_W){1'b0}}, sq_q};
          abs_sum_d = abs_sum_q + {{(BW-AW){1'b0}}, ad_q};
          cnt_d     = cnt_q + 1'b1;
        end
        state_d = last_q ? ST_CHK : ST_IDLE;
      end
      ST_CHK: begin
        if (cnt_q == '0) begin
          mae_d   = '0;
          rmse_d  = '0;
          state_d = ST_OUT;
        end else begin
          cmd.start = 1'b1;
          state_d   = ST_WDA;
        end
      end
      ST_WDA: begin
        if (sts.done) begin
          mae_d     = unit_res[OW-1:0];
          cmd.start = 1'b1;
          unit_x    = sq_sum_q;
          state_d   = ST_WDS;
        end
      end
      ST_WDS: begin
        if (sts.done) begin
          cmd.start = 1'b1;
          cmd.op    = rem_pkg::OP_SQRT;
          unit_x    = unit_res;
          state_d   = ST_WSR;
        end
      end
      ST_WSR: begin
        if (sts.done) begin
          rmse_d  = unit_res[OW-1:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_rmse_d  = rmse_q;
          out_mae_d   = mae_q;
          out_cnt_d   = cnt_q;
          out_flag_d  = (cnt_q == '0);
          sq_sum_d    = '0;
          abs_sum_d   = '0;
          cnt_d       = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sq_sum_q    <= '0;
      abs_sum_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sq_sum_q    <= sq_sum_d;
      abs_sum_q   <= abs_sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ad_q       <= ad_d;
    sq_q       <= sq_d;
    take_q     <= take_d;
    last_q     <= last_d;
    mae_q      <= mae_d;
    rmse_q     <= rmse_d;
    out_rmse_q <= out_rmse_d;
    out_mae_q  <= out_mae_d;
    out_cnt_q  <= out_cnt_d;
    out_flag_q <= out_flag_d;
  end

  assign out_valid_o     = out_valid_q;
  assign rmse_value_o    = out_rmse_q;
  assign mae_value_o     = out_mae_q;
  assign valid_total_o   = out_cnt_q;
  assign no_valid_flag_o = out_flag_q;

endmodule
